@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the refractive index lookup.
// No dependencies; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks an implication or expression on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ src/iril_pkg.sv @@
// Constants, types, wavelength/index ROM and the divider step function
// for the refractive index lookup. No dependencies.
package iril_pkg;

	localparam int ROM_SIZE          = 36;
	localparam int TABLE_ENTRIES_DEF = 36;
	localparam int WL_W              = 16;
	localparam int VAL_W             = 13;
	// Widest segment of the ROM is 4134, so its span fits in 13 bits.
	localparam int DEN_W             = 13;
	// Rounded numerator is below 2^25; one spare bit keeps the top of the
	// divider accumulator equal to the divisor width.
	localparam int NUM_W             = DEN_W + VAL_W;
	localparam int MAX_STEPS         = 4;

	typedef logic [WL_W-1:0]  wl_t;
	typedef logic [VAL_W-1:0] val_t;
	typedef logic [DEN_W-1:0] den_t;
	typedef logic [NUM_W-1:0] num_t;

	localparam wl_t ROM_WL [ROM_SIZE] = '{
		16'd1240,  16'd1350,  16'd1378,  16'd1459,  16'd1550,  16'd1653,
		16'd1771,  16'd1907,  16'd2066,  16'd2254,  16'd2480,  16'd2755,
		16'd3100,  16'd3306,  16'd3542,  16'd3815,  16'd4133,  16'd4275,
		16'd4428,  16'd4592,  16'd4769,  16'd4959,  16'd5166,  16'd5391,
		16'd5636,  16'd5904,  16'd6199,  16'd6526,  16'd6888,  16'd7293,
		16'd7749,  16'd8266,  16'd12400, 16'd13780, 16'd15500, 16'd17710
	};

	localparam val_t ROM_RE [ROM_SIZE] = '{
		13'd930,  13'd925,  13'd920,  13'd920,  13'd920,  13'd960,
		13'd1000, 13'd1100, 13'd1300, 13'd1380, 13'd1394, 13'd1953,
		13'd3905, 13'd3947, 13'd4020, 13'd4144, 13'd4082, 13'd4037,
		13'd4035, 13'd4082, 13'd4180, 13'd4340, 13'd4610, 13'd5062,
		13'd5283, 13'd5748, 13'd5588, 13'd5380, 13'd5067, 13'd4897,
		13'd4763, 13'd4653, 13'd4325, 13'd4285, 13'd4275, 13'd4180
	};

	localparam val_t ROM_IM [ROM_SIZE] = '{
		13'd860,  13'd1000, 13'd1140, 13'd1200, 13'd1400, 13'd1600,
		13'd1800, 13'd2050, 13'd2340, 13'd2842, 13'd3197, 13'd4297,
		13'd3336, 13'd2922, 13'd2667, 13'd2405, 13'd2145, 13'd2140,
		13'd2181, 13'd2240, 13'd2309, 13'd2384, 13'd2455, 13'd2318,
		13'd2049, 13'd1634, 13'd933,  13'd638,  13'd500,  13'd401,
		13'd345,  13'd298,  13'd81,   13'd75,   13'd57,   13'd28
	};

	// Restoring division steps on an accumulator {remainder, dividend bits}.
	// Each step shifts one dividend bit into the remainder and one quotient
	// bit into the bottom; after VAL_W steps the low half is the quotient.
	function automatic num_t div_steps(input num_t acc, input den_t den,
			input int unsigned steps);
		logic [DEN_W:0]       t;
		logic [DEN_W-1:0]     rem;
		logic [VAL_W-1:0]     low;
		logic                 qbit;
		rem = acc[NUM_W-1:VAL_W];
		low = acc[VAL_W-1:0];
		for (int i = 0; i < MAX_STEPS; i++) begin
			if (i < steps) begin
				t    = {rem, low[VAL_W-1]};
				qbit = (t >= {1'b0, den});
				if (qbit) begin
					t = t - {1'b0, den};
				end
				rem = t[DEN_W-1:0];
				low = {low[VAL_W-2:0], qbit};
			end
		end
		return {rem, low};
	endfunction

endpackage

@@ src/interpolated_refractive_index_lookup.sv @@
// Top level of the refractive index lookup: segment search, blend and a
// pipelined rounding divider. Depends on iril_pkg and assert_macros.svh.
//
// Takes one wavelength beat per clock and returns one beat with the real
// index and the extinction coefficient, linearly interpolated in a 36-point
// ROM and rounded to the nearest 0.001; queries outside the ROM clamp to the
// end entries. The stages are a parallel compare against every
// ROM point, the segment select and distance subtract, the two products per
// part, the rounding sum, and four stages of the restoring divider that
// retire four, three, three and three quotient bits. The pipeline moves as a
// whole and only holds while the output beat waits, so throughput is one
// beat per cycle whenever m_axis_tready stays high.
`include "assert_macros.svh"

module interpolated_refractive_index_lookup #(
	parameter int TABLE_ENTRIES = iril_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] wavelength
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [12:0] index_real, [25:13] index_imag, rest zero
);
	import iril_pkg::*;

	localparam int USED  = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE : TABLE_ENTRIES;
	localparam int LAST  = USED - 1;
	localparam int PAD_W = 32 - 2 * VAL_W;

	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	wl_t              wl_s1;
	logic [USED-1:0]  ge_s1;

	val_t a_re_s2, b_re_s2, a_im_s2, b_im_s2;
	den_t d1_s2, d2_s2;

	num_t pa_re_s3, pb_re_s3, pa_im_s3, pb_im_s3;
	den_t den_s3;

	num_t num_re_s4, num_im_s4;
	den_t den_s4;

	num_t acc_re_s5, acc_im_s5, acc_re_s6, acc_im_s6;
	num_t acc_re_s7, acc_im_s7, acc_re_s8, acc_im_s8;
	den_t den_s5, den_s6, den_s7;

	// Whole pipeline advances unless the output beat is stalled.
	assign en            = !v_s8 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = v_s8;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, acc_im_s8[VAL_W-1:0], acc_re_s8[VAL_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Stage 1: compare the query against every ROM point.
	always_ff @(posedge clk) begin
		if (en) begin
			wl_s1 <= s_axis_tdata[WL_W-1:0];
			for (int k = 0; k < USED; k++) begin
				ge_s1[k] <= (s_axis_tdata[WL_W-1:0] >= ROM_WL[k]);
			end
		end
	end

	// Stage 2: pick the segment whose lower point is the last one passed.
	// A query on the last point or outside the ROM takes a clamp entry with
	// zero distance to the first value and unit span, which returns it exactly.
	logic [LAST-1:0] seg_sel;
	wl_t             w_lo, w_hi, d1_full, d2_full;
	val_t            re_lo, re_hi, im_lo, im_hi;
	val_t            re_c, im_c;
	den_t            d1_c, d2_c;
	val_t            re_lo_c, re_hi_c, im_lo_c, im_hi_c;

	always_comb begin
		w_lo  = '0;
		w_hi  = '0;
		re_lo = '0;
		re_hi = '0;
		im_lo = '0;
		im_hi = '0;
		for (int k = 0; k < LAST; k++) begin
			seg_sel[k] = ge_s1[k] & ~ge_s1[k+1];
			w_lo  = w_lo  | ({WL_W{seg_sel[k]}}  & ROM_WL[k]);
			w_hi  = w_hi  | ({WL_W{seg_sel[k]}}  & ROM_WL[k+1]);
			re_lo = re_lo | ({VAL_W{seg_sel[k]}} & ROM_RE[k]);
			re_hi = re_hi | ({VAL_W{seg_sel[k]}} & ROM_RE[k+1]);
			im_lo = im_lo | ({VAL_W{seg_sel[k]}} & ROM_IM[k]);
			im_hi = im_hi | ({VAL_W{seg_sel[k]}} & ROM_IM[k+1]);
		end
		d1_full = wl_s1 - w_lo;
		d2_full = w_hi - wl_s1;
		re_c = ge_s1[0] ? ROM_RE[LAST] : ROM_RE[0];
		im_c = ge_s1[0] ? ROM_IM[LAST] : ROM_IM[0];
		if (seg_sel != '0) begin
			d1_c    = d1_full[DEN_W-1:0];
			d2_c    = d2_full[DEN_W-1:0];
			re_lo_c = re_lo;
			re_hi_c = re_hi;
			im_lo_c = im_lo;
			im_hi_c = im_hi;
		end else begin
			d1_c    = '0;
			d2_c    = DEN_W'(1);
			re_lo_c = re_c;
			re_hi_c = re_c;
			im_lo_c = im_c;
			im_hi_c = im_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_re_s2 <= re_lo_c;
			b_re_s2 <= re_hi_c;
			a_im_s2 <= im_lo_c;
			b_im_s2 <= im_hi_c;
			d1_s2   <= d1_c;
			d2_s2   <= d2_c;
		end
	end

	// Stage 3: distance-weighted products; the span is d1 + d2.
	logic [DEN_W:0] den_sum;
	assign den_sum = {1'b0, d1_s2} + {1'b0, d2_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			pa_re_s3 <= NUM_W'(a_re_s2) * NUM_W'(d2_s2);
			pb_re_s3 <= NUM_W'(b_re_s2) * NUM_W'(d1_s2);
			pa_im_s3 <= NUM_W'(a_im_s2) * NUM_W'(d2_s2);
			pb_im_s3 <= NUM_W'(b_im_s2) * NUM_W'(d1_s2);
			den_s3   <= den_sum[DEN_W-1:0];
		end
	end

	// Stage 4: sum the products and add half the span for round to nearest.
	logic [NUM_W:0] sum_re, sum_im;
	assign sum_re = {1'b0, pa_re_s3} + {1'b0, pb_re_s3} + (NUM_W+1)'(den_s3 >> 1);
	assign sum_im = {1'b0, pa_im_s3} + {1'b0, pb_im_s3} + (NUM_W+1)'(den_s3 >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			num_re_s4 <= sum_re[NUM_W-1:0];
			num_im_s4 <= sum_im[NUM_W-1:0];
			den_s4    <= den_s3;
		end
	end

	// Stages 5 to 8: restoring divider, 4 + 3 + 3 + 3 quotient bits.
	always_ff @(posedge clk) begin
		if (en) begin
			acc_re_s5 <= div_steps(num_re_s4, den_s4, 4);
			acc_im_s5 <= div_steps(num_im_s4, den_s4, 4);
			den_s5    <= den_s4;
			acc_re_s6 <= div_steps(acc_re_s5, den_s5, 3);
			acc_im_s6 <= div_steps(acc_im_s5, den_s5, 3);
			den_s6    <= den_s5;
			acc_re_s7 <= div_steps(acc_re_s6, den_s6, 3);
			acc_im_s7 <= div_steps(acc_im_s6, den_s6, 3);
			den_s7    <= den_s6;
			acc_re_s8 <= div_steps(acc_re_s7, den_s7, 3);
			acc_im_s8 <= div_steps(acc_im_s7, den_s7, 3);
		end
	end

	// At most one segment may claim a query.
	`ASSERT_CLK(a_seg_onehot, clk, arst_n, v_s1 |-> $onehot0(seg_sel), "two segments selected")
	// The divisor of a live beat is never zero.
	`ASSERT_NEVER(a_den_zero, clk, arst_n, v_s4 && (den_s4 == '0), "zero interpolation span")
	// The quotient must fit: the top of the numerator stays below the divisor.
	`ASSERT_CLK(a_div_range, clk, arst_n, v_s4 |-> ((num_re_s4[NUM_W-1:VAL_W] < den_s4) && (num_im_s4[NUM_W-1:VAL_W] < den_s4)), "quotient overflow")

endmodule
